// ===== rtl/dtpg_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpg_pkg
// Shared widths, colours, mode and register codes, hash constants and
// small colour lookup functions for the display test pattern generator.
// ----------------------------------------------------------------------------
package dtpg_pkg;

  // default geometry
  localparam int DEF_SCREEN_WIDTH  = 240;
  localparam int DEF_SCREEN_HEIGHT = 135;
  localparam int DEF_CHECK_SIZE    = 12;
  localparam int DEF_NOISE_BLOCK   = 8;
  localparam int DEF_STRIPE_HEIGHT = 10;

  // channel widths
  localparam int COORD_W    = 8;
  localparam int COLOUR_W   = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MODE_W;

  typedef logic [COLOUR_W-1:0] colour_t;

  localparam colour_t C_RED   = 16'hF800;
  localparam colour_t C_GREEN = 16'h07E0;
  localparam colour_t C_BLUE  = 16'h001F;
  localparam colour_t C_WHITE = 16'hFFFF;
  localparam colour_t C_BLACK = 16'h0000;
  localparam colour_t C_HALO  = 16'h2104;

  typedef enum logic [MODE_W-1:0] {
    MODE_FLASH,
    MODE_RAMP,
    MODE_CHECKER,
    MODE_HASH,
    MODE_CROSS,
    MODE_STRIPE
  } mode_e;

  localparam int MODE_COUNT = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSED = 2'd1;

  // ramp runs red, green, blue, white, black
  localparam int RAMP_LEN = 5;
  localparam int RAMP_W   = 3;

  // walker arms change colour every ARM_SPAN columns, cycling over three
  localparam int ARM_SPAN   = 80;
  localparam int ARM_CNT_W  = $clog2(ARM_SPAN);
  localparam int ARM_COUNT  = 3;
  localparam int ARM_SEL_W  = 2;

  // halo rows on each side of the sweep stripe
  localparam int HALO_ROWS = 2;

  // noise hash
  localparam logic [31:0] SEED_RESET = 32'd1;
  localparam logic [31:0] HASH_MUL_X = 32'h9E3779B1;
  localparam logic [31:0] HASH_MUL_Y = 32'h85EBCA77;
  localparam logic [31:0] HASH_MIX_A = 32'h7FEB352D;
  localparam logic [31:0] HASH_MIX_B = 32'h846CA68B;

  // reciprocal shift, exact for 8-bit coordinates and divisors up to 256
  localparam int RECIP_SHIFT = 16;

  function automatic colour_t ramp_colour(logic [RAMP_W-1:0] step);
    colour_t c;
    case (step)
      3'd0, 3'd5: c = C_RED;
      3'd1, 3'd6: c = C_GREEN;
      3'd2, 3'd7: c = C_BLUE;
      3'd3:       c = C_WHITE;
      default:    c = C_BLACK;
    endcase
    return c;
  endfunction

  function automatic colour_t arm_colour(logic [ARM_SEL_W-1:0] sel);
    colour_t c;
    case (sel)
      2'd0:    c = C_RED;
      2'd1:    c = C_GREEN;
      default: c = C_BLUE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/dtpg_if.sv =====
// ----------------------------------------------------------------------------
// dtpg channel interfaces
// Valid/ready channels for pixel coordinates, pixel colours and register
// writes of the display test pattern generator.
// ----------------------------------------------------------------------------
interface dtpg_pix_if;
  logic                             valid;
  logic                             ready;
  logic [dtpg_pkg::COORD_W-1:0]     pixel_x;
  logic [dtpg_pkg::COORD_W-1:0]     pixel_y;
  logic                             frame_last;

  modport source (output valid, output pixel_x, output pixel_y, output frame_last,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input frame_last,
                  output ready);
endinterface

interface dtpg_col_if;
  logic                             valid;
  logic                             ready;
  logic [dtpg_pkg::COLOUR_W-1:0]    pixel_colour;

  modport source (output valid, output pixel_colour, input ready);
  modport sink   (input valid, input pixel_colour, output ready);
endinterface

interface dtpg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dtpg_pkg::CFG_IDX_W-1:0]   index;
  logic [dtpg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/display_test_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// display_test_pattern_generator
// Maps raster pixel coordinates to an RGB565 colour from one of six LCD
// test patterns; per-frame pattern state steps on the last pixel of a frame.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents                        handshake
//  cfg_i    in   index, data (mode / paused)          valid, ready (always 1)
//  pix_i    in   pixel_x, pixel_y, frame_last         valid, ready
//  col_o    out  pixel_colour                         valid, ready
//
//  One pixel per clock sustained while col_o is ready; a colour passes the five
//  register stages around the noise hash multipliers (block index, seed mix,
//  two mixing rounds, output) before it leaves.
//  Unpaused, pattern state steps at an edge that takes a frame_last beat and no cfg write.
//  Reset and a mode write return pattern state to start of sequence.
//  pix_i.ready falls only when all five stages hold beats and col_o stalls.
// ----------------------------------------------------------------------------
module display_test_pattern_generator #(
  parameter int SCREEN_WIDTH  = dtpg_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = dtpg_pkg::DEF_SCREEN_HEIGHT,
  parameter int CHECK_SIZE    = dtpg_pkg::DEF_CHECK_SIZE,
  parameter int NOISE_BLOCK   = dtpg_pkg::DEF_NOISE_BLOCK,
  parameter int STRIPE_HEIGHT = dtpg_pkg::DEF_STRIPE_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dtpg_cfg_if.sink          cfg_i,
  dtpg_pix_if.sink          pix_i,
  dtpg_col_if.source        col_o
);

  localparam int COORD_W = dtpg_pkg::COORD_W;
  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
  localparam int XCMP_W  = ((COL_W > COORD_W) ? COL_W : COORD_W) + 1;
  localparam int YCMP_W  = ((ROW_W > COORD_W) ? ROW_W : COORD_W) + 1;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);

  localparam int STRIPE_STEP = STRIPE_HEIGHT % SCREEN_HEIGHT;

  localparam int MUL_W  = dtpg_pkg::RECIP_SHIFT + 1;
  localparam int PROD_W = MUL_W + COORD_W;
  localparam int CK_MUL = ((1 << dtpg_pkg::RECIP_SHIFT) + CHECK_SIZE - 1) / CHECK_SIZE;
  localparam int NB_MUL = ((1 << dtpg_pkg::RECIP_SHIFT) + NOISE_BLOCK - 1) / NOISE_BLOCK;

  localparam logic [dtpg_pkg::ARM_CNT_W-1:0] ARM_CNT_LAST =
    dtpg_pkg::ARM_CNT_W'(dtpg_pkg::ARM_SPAN - 1);
  localparam logic [dtpg_pkg::ARM_SEL_W-1:0] ARM_SEL_LAST =
    dtpg_pkg::ARM_SEL_W'(dtpg_pkg::ARM_COUNT - 1);
  localparam logic [dtpg_pkg::RAMP_W-1:0] RAMP_LAST =
    dtpg_pkg::RAMP_W'(dtpg_pkg::RAMP_LEN - 1);

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  logic cfg_acc, pix_acc;
  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic en_a, en_b, en_c, en_d, en_e;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  // a stage moves when it is empty or the next one moves
  assign en_e = !ve_q || col_o.ready;
  assign en_d = !vd_q || en_e;
  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;

  assign pix_i.ready = en_a;
  assign pix_acc     = pix_i.valid && en_a;

  // --------------------------------------------------------------------------
  // configuration and pattern state
  // --------------------------------------------------------------------------
  dtpg_pkg::mode_e                 mode_q, mode_d;
  logic                            paused_q, paused_d;
  logic                            flash_q, flash_d;
  logic [dtpg_pkg::RAMP_W-1:0]     ramp_q, ramp_d;
  logic                            parity_q, parity_d;
  logic [COL_W-1:0]                wcol_q, wcol_d;
  logic [ROW_W-1:0]                wrow_q, wrow_d;
  logic [dtpg_pkg::ARM_CNT_W-1:0]  arm_cnt_q, arm_cnt_d;
  logic [dtpg_pkg::ARM_SEL_W-1:0]  arm_sel_q, arm_sel_d;
  logic [ROW_W-1:0]                top_q, top_d;
  logic [31:0]                     seed_q, seed_d;

  logic [dtpg_pkg::MODE_W-1:0]     mode_wr;
  logic [31:0]                     xs1, xs2, xs3;
  logic [ROW_W:0]                  top_sum;
  logic [ROW_W:0]                  top_wrap;

  assign mode_wr = (cfg_i.data >= dtpg_pkg::MODE_W'(dtpg_pkg::MODE_COUNT))
                 ? cfg_i.data - dtpg_pkg::MODE_W'(dtpg_pkg::MODE_COUNT)
                 : cfg_i.data;

  // xorshift32 seed step
  assign xs1 = seed_q ^ (seed_q << 13);
  assign xs2 = xs1 ^ (xs1 >> 17);
  assign xs3 = xs2 ^ (xs2 << 5);

  assign top_sum  = {1'b0, top_q} + (ROW_W + 1)'(STRIPE_STEP);
  assign top_wrap = (top_sum >= (ROW_W + 1)'(SCREEN_HEIGHT))
                  ? top_sum - (ROW_W + 1)'(SCREEN_HEIGHT)
                  : top_sum;

  always_comb begin
    mode_d    = mode_q;
    paused_d  = paused_q;
    flash_d   = flash_q;
    ramp_d    = ramp_q;
    parity_d  = parity_q;
    wcol_d    = wcol_q;
    wrow_d    = wrow_q;
    arm_cnt_d = arm_cnt_q;
    arm_sel_d = arm_sel_q;
    top_d     = top_q;
    seed_d    = seed_q;
    if (cfg_acc) begin
      if (cfg_i.index == dtpg_pkg::REG_MODE) begin
        mode_d    = dtpg_pkg::mode_e'(mode_wr);
        flash_d   = 1'b0;
        ramp_d    = '0;
        parity_d  = 1'b0;
        wcol_d    = '0;
        wrow_d    = '0;
        arm_cnt_d = '0;
        arm_sel_d = '0;
        top_d     = '0;
        seed_d    = dtpg_pkg::SEED_RESET;
      end else if (cfg_i.index == dtpg_pkg::REG_PAUSED) begin
        paused_d = cfg_i.data[0];
      end
    end else if (pix_acc && pix_i.frame_last && !paused_q) begin
      case (mode_q)
        dtpg_pkg::MODE_FLASH: begin
          flash_d = !flash_q;
        end
        dtpg_pkg::MODE_RAMP: begin
          ramp_d = (ramp_q >= RAMP_LAST) ? '0 : ramp_q + 1'b1;
        end
        dtpg_pkg::MODE_CHECKER: begin
          parity_d = !parity_q;
        end
        dtpg_pkg::MODE_HASH: begin
          seed_d = xs3;
        end
        dtpg_pkg::MODE_CROSS: begin
          if (wcol_q == COL_LAST) begin
            wcol_d    = '0;
            arm_cnt_d = '0;
            arm_sel_d = '0;
            wrow_d    = (wrow_q == ROW_LAST) ? '0 : wrow_q + 1'b1;
          end else begin
            wcol_d = wcol_q + 1'b1;
            // arm colour index tracks column / span mod three
            if (arm_cnt_q == ARM_CNT_LAST) begin
              arm_cnt_d = '0;
              arm_sel_d = (arm_sel_q == ARM_SEL_LAST) ? '0 : arm_sel_q + 1'b1;
            end else begin
              arm_cnt_d = arm_cnt_q + 1'b1;
            end
          end
        end
        default: begin
          top_d = top_wrap[ROW_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= dtpg_pkg::MODE_FLASH;
      paused_q  <= 1'b0;
      flash_q   <= 1'b0;
      ramp_q    <= '0;
      parity_q  <= 1'b0;
      wcol_q    <= '0;
      wrow_q    <= '0;
      arm_cnt_q <= '0;
      arm_sel_q <= '0;
      top_q     <= '0;
      seed_q    <= dtpg_pkg::SEED_RESET;
    end else begin
      mode_q    <= mode_d;
      paused_q  <= paused_d;
      flash_q   <= flash_d;
      ramp_q    <= ramp_d;
      parity_q  <= parity_d;
      wcol_q    <= wcol_d;
      wrow_q    <= wrow_d;
      arm_cnt_q <= arm_cnt_d;
      arm_sel_q <= arm_sel_d;
      top_q     <= top_d;
      seed_q    <= seed_d;
    end
  end

  // --------------------------------------------------------------------------
  // pixel colour from current state, formed at the accepting edge
  // --------------------------------------------------------------------------
  logic [XCMP_W-1:0]      x_w, col_w;
  logic [YCMP_W-1:0]      y_w, row_w, top_w, end_w;
  logic                   off_scr;
  dtpg_pkg::colour_t      arm_c, walk_c, sweep_c, base_c;
  logic [PROD_W-1:0]      ck_px, ck_py, nb_px, nb_py;

  assign x_w   = XCMP_W'(pix_i.pixel_x);
  assign y_w   = YCMP_W'(pix_i.pixel_y);
  assign col_w = XCMP_W'(wcol_q);
  assign row_w = YCMP_W'(wrow_q);
  assign top_w = YCMP_W'(top_q);
  assign end_w = top_w + YCMP_W'(STRIPE_HEIGHT);

  assign off_scr = (x_w >= XCMP_W'(SCREEN_WIDTH)) || (y_w >= YCMP_W'(SCREEN_HEIGHT));

  assign arm_c = dtpg_pkg::arm_colour(arm_sel_q);

  always_comb begin
    if (x_w == col_w && y_w == row_w) begin
      walk_c = dtpg_pkg::C_WHITE;
    end else if (y_w == row_w && (x_w + 1'b1 == col_w || x_w == col_w + 1'b1)) begin
      walk_c = arm_c;
    end else if (x_w == col_w && (y_w + 1'b1 == row_w || y_w == row_w + 1'b1)) begin
      walk_c = arm_c;
    end else begin
      walk_c = dtpg_pkg::C_BLACK;
    end
  end

  always_comb begin
    if (y_w >= top_w && y_w < end_w) begin
      sweep_c = dtpg_pkg::C_WHITE;
    end else if (top_w >= YCMP_W'(dtpg_pkg::HALO_ROWS)
                 && y_w >= top_w - YCMP_W'(dtpg_pkg::HALO_ROWS) && y_w < top_w) begin
      sweep_c = dtpg_pkg::C_HALO;
    end else if (end_w + YCMP_W'(dtpg_pkg::HALO_ROWS) <= YCMP_W'(SCREEN_HEIGHT)
                 && y_w >= end_w && y_w < end_w + YCMP_W'(dtpg_pkg::HALO_ROWS)) begin
      sweep_c = dtpg_pkg::C_HALO;
    end else begin
      sweep_c = dtpg_pkg::C_BLACK;
    end
  end

  always_comb begin
    case (mode_q)
      dtpg_pkg::MODE_FLASH:   base_c = flash_q ? dtpg_pkg::C_WHITE : dtpg_pkg::C_BLACK;
      dtpg_pkg::MODE_RAMP:    base_c = dtpg_pkg::ramp_colour(ramp_q);
      dtpg_pkg::MODE_CHECKER: base_c = dtpg_pkg::C_BLACK;
      dtpg_pkg::MODE_HASH:    base_c = dtpg_pkg::C_BLACK;
      dtpg_pkg::MODE_CROSS:   base_c = walk_c;
      default:                base_c = sweep_c;
    endcase
  end

  // constant division by reciprocal multiply
  assign ck_px = PROD_W'(pix_i.pixel_x) * PROD_W'(CK_MUL);
  assign ck_py = PROD_W'(pix_i.pixel_y) * PROD_W'(CK_MUL);
  assign nb_px = PROD_W'(pix_i.pixel_x) * PROD_W'(NB_MUL);
  assign nb_py = PROD_W'(pix_i.pixel_y) * PROD_W'(NB_MUL);

  // --------------------------------------------------------------------------
  // stage a: block indexes, checker bit, base colour
  // --------------------------------------------------------------------------
  logic                   chk_a_q, hash_a_q, off_a_q, par_a_q;
  dtpg_pkg::colour_t      base_a_q;
  logic [COORD_W-1:0]     bx_a_q, by_a_q;
  logic [31:0]            seed_a_q;

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      chk_a_q  <= (mode_q == dtpg_pkg::MODE_CHECKER);
      hash_a_q <= (mode_q == dtpg_pkg::MODE_HASH) && !off_scr;
      off_a_q  <= off_scr;
      par_a_q  <= parity_q;
      base_a_q <= base_c;
      bx_a_q   <= nb_px[dtpg_pkg::RECIP_SHIFT +: COORD_W];
      by_a_q   <= nb_py[dtpg_pkg::RECIP_SHIFT +: COORD_W];
      seed_a_q <= seed_q;
    end
  end

  logic chk_bit_a_q;
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      chk_bit_a_q <= ck_px[dtpg_pkg::RECIP_SHIFT] ^ ck_py[dtpg_pkg::RECIP_SHIFT];
    end
  end

  // --------------------------------------------------------------------------
  // stage b: seed mix, final colour for every pattern but noise
  // --------------------------------------------------------------------------
  logic                   hash_b_q;
  dtpg_pkg::colour_t      col_b_q, col_a;
  logic [31:0]            h0_b_q, h0;

  always_comb begin
    if (off_a_q) begin
      col_a = dtpg_pkg::C_BLACK;
    end else if (chk_a_q) begin
      col_a = (chk_bit_a_q ^ par_a_q) ? dtpg_pkg::C_WHITE : dtpg_pkg::C_BLACK;
    end else begin
      col_a = base_a_q;
    end
  end

  assign h0 = seed_a_q ^ (32'(bx_a_q) * dtpg_pkg::HASH_MUL_X)
                       ^ (32'(by_a_q) * dtpg_pkg::HASH_MUL_Y);

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      hash_b_q <= hash_a_q;
      col_b_q  <= col_a;
      h0_b_q   <= h0;
    end
  end

  // --------------------------------------------------------------------------
  // stages c and d: hash mixing rounds
  // --------------------------------------------------------------------------
  logic                   hash_c_q, hash_d_q;
  dtpg_pkg::colour_t      col_c_q, col_d_q;
  logic [31:0]            h1_c_q, h2_d_q, hm_b, hm_c;

  assign hm_b = h0_b_q ^ (h0_b_q >> 16);
  assign hm_c = h1_c_q ^ (h1_c_q >> 15);

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      hash_c_q <= hash_b_q;
      col_c_q  <= col_b_q;
      h1_c_q   <= hm_b * dtpg_pkg::HASH_MIX_A;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      hash_d_q <= hash_c_q;
      col_d_q  <= col_c_q;
      h2_d_q   <= hm_c * dtpg_pkg::HASH_MIX_B;
    end
  end

  // --------------------------------------------------------------------------
  // stage e: result register
  // --------------------------------------------------------------------------
  dtpg_pkg::colour_t out_q;

  // top half of h ^ (h >> 16) is just the top half of h
  always_ff @(posedge clk_i) begin
    if (en_e) begin
      out_q <= hash_d_q ? h2_d_q[31:16] : col_d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_a) va_q <= pix_i.valid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_d) vd_q <= vc_q;
      if (en_e) ve_q <= vd_q;
    end
  end

  assign col_o.valid        = ve_q;
  assign col_o.pixel_colour = out_q;

`ifndef NO_ASSERTIONS
  // xorshift from a nonzero seed never reaches zero
  a_seed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q != '0)
    else $error("noise seed reached zero");

  // a paused beat leaves pattern state alone
  a_paused_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && paused_q && !cfg_acc) |=>
      ($stable(seed_q) && $stable(wcol_q) && $stable(wrow_q) && $stable(top_q)
       && $stable(ramp_q) && $stable(flash_q) && $stable(parity_q)))
    else $error("pattern state moved while paused");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wcol_q <= COL_LAST) && (wrow_q <= ROW_LAST)
    && ({1'b0, top_q} < (ROW_W + 1)'(SCREEN_HEIGHT)) && (arm_cnt_q <= ARM_CNT_LAST))
    else $error("walker or stripe position out of range");

  // an accepted beat always lands in the first stage
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> va_q)
    else $error("accepted beat lost at stage a");
`endif

endmodule
